>>> rtl/core/vcw_pkg.sv
// shared types and constants of the vertex cluster weld block
// no dependencies; imported by every module of the block
package vcw_pkg;

  // table sizes
  localparam int HASH_SLOTS     = 8192;
  localparam int MAX_CLUSTERS   = 4096;
  localparam int CELL_INDEX_MAX = 1023;

  // derived widths
  localparam int HASH_W    = $clog2(HASH_SLOTS);
  localparam int CLU_W     = $clog2(MAX_CLUSTERS);
  localparam int CLU_CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int CELL_W    = $clog2(CELL_INDEX_MAX + 1);

  // field widths
  localparam int COORD_W = 24;
  localparam int CS_W    = 23;
  localparam int KEY_W   = 40;
  localparam int SUM_W   = 40;
  localparam int CNT_W   = 16;
  localparam int QIDX_W  = 12;
  localparam int DIV_W   = SUM_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int LANES   = 3;

  // spatial hash primes and multiplicative scrambler
  localparam logic [KEY_W-1:0] PRIME_X = KEY_W'(73856093);
  localparam logic [KEY_W-1:0] PRIME_Y = KEY_W'(19349663);
  localparam logic [KEY_W-1:0] PRIME_Z = KEY_W'(83492791);
  localparam logic [31:0]      SCRAMBLE = 32'd2654435761;

  localparam logic [CNT_W-1:0]  PASS_LIMIT = {CNT_W{1'b1}};
  localparam logic [CS_W-1:0]   CS_RESET   = CS_W'(256);

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_BAD_INDEX  = 2'd2,
    STAT_PASS_LIMIT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X  = 2'd0,
    CFG_ORIGIN_Y  = 2'd1,
    CFG_ORIGIN_Z  = 2'd2,
    CFG_CELL_SIZE = 2'd3
  } cfg_e;

  // hash slot word
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CLU_W-1:0] cluster;
  } slot_entry_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [HASH_W-1:0] addr;
    slot_entry_t       wdata;
  } slot_req_t;

  // cluster accumulator word
  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [SUM_W-1:0] sum_z;
    logic [CNT_W-1:0] count;
  } clu_entry_t;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [CLU_W-1:0] addr;
    clu_entry_t       wdata;
  } clu_req_t;

endpackage

>>> rtl/core/vertex_cluster_weld.sv
// top level of the vertex cluster weld block: control sequencer and registers
// depends on vcw_pkg, vcw_divider, vcw_slot_table, vcw_cluster_store
//
// One transaction is worked at a time. Busy is high until its result has been
// set up. Each result shows on the outputs for one cycle with done_o high, and
// the receiver cannot hold a result off.
// An add-vertex transaction passes through the bit-serial cell divider, key and
// slot hashing, a read and a check per probe of the single-port slot memory,
// and an update of the cluster memory. A read fetches the cluster entry and
// divides its sums in the divider for the average. A bad index, a pass-limit
// reject or an unknown function answers straight from idle. A clear, and
// reset, sweep the 8192 hash slots at one per cycle, with busy high throughout.
module vertex_cluster_weld (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [vcw_pkg::COORD_W-1:0] cfg_data_i,
  // command
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func_i,
  input  logic signed [vcw_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [vcw_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [vcw_pkg::COORD_W-1:0] coord_z_i,
  input  logic [vcw_pkg::QIDX_W-1:0]  query_index_i,
  // result
  output logic                        done_o,
  output logic [vcw_pkg::CLU_W-1:0]   cluster_id_o,
  output logic                        created_o,
  output logic                        triangle_done_o,
  output logic                        triangle_kept_o,
  output logic signed [vcw_pkg::COORD_W-1:0] mean_x_o,
  output logic signed [vcw_pkg::COORD_W-1:0] mean_y_o,
  output logic signed [vcw_pkg::COORD_W-1:0] mean_z_o,
  output logic [vcw_pkg::CNT_W-1:0]   member_count_o,
  output logic [1:0]                  status_o
);
  import vcw_pkg::*;

  localparam logic [3:0] S_SWEEP     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DIV       = 4'd2;
  localparam logic [3:0] S_MUL       = 4'd3;
  localparam logic [3:0] S_HASH      = 4'd4;
  localparam logic [3:0] S_PROBE_RD  = 4'd5;
  localparam logic [3:0] S_PROBE_CHK = 4'd6;
  localparam logic [3:0] S_CL_WR     = 4'd7;
  localparam logic [3:0] S_VFIN      = 4'd8;
  localparam logic [3:0] S_RD_WAIT   = 4'd9;
  localparam logic [3:0] S_RD_DIV    = 4'd10;

  typedef struct packed {
    logic [CLU_W-1:0]   cluster_id;
    logic               created;
    logic               tri_done;
    logic               tri_kept;
    logic [COORD_W-1:0] mean_x;
    logic [COORD_W-1:0] mean_y;
    logic [COORD_W-1:0] mean_z;
    logic [CNT_W-1:0]   count;
    status_e            status;
  } res_t;

  // configuration
  logic [COORD_W-1:0] org_q [LANES];
  logic [CS_W-1:0]    cs_q;

  // control and pass state
  logic [3:0]           state_q, state_d;
  logic [HASH_W-1:0]    sweep_q, sweep_d;
  logic                 sweep_rep_q, sweep_rep_d;
  logic [CLU_CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0]     pass_q, pass_d;
  logic [1:0]           corner_q, corner_d;
  logic [CLU_W-1:0]     first_q, first_d, second_q, second_d;
  logic                 done_q, done_d;
  res_t                 res_q, res_d;

  // per-transaction payload
  logic [COORD_W-1:0] coord_q [LANES];
  logic [COORD_W-1:0] coord_d [LANES];
  logic [CELL_W-1:0]  cell_q [LANES];
  logic [CELL_W-1:0]  cell_d [LANES];
  logic [KEY_W-1:0]   prod_q [LANES];
  logic [KEY_W-1:0]   prod_d [LANES];
  logic [KEY_W-1:0]   key_q, key_d;
  logic [HASH_W-1:0]  hash_q, hash_d, probe_q, probe_d;
  logic [CLU_W-1:0]   idx_q, idx_d;
  logic               created_q, created_d;
  logic [LANES-1:0]   neg_q, neg_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // datapath helpers
  logic                         accept;
  logic [COORD_W:0]             offs [LANES];
  logic [31:0]                  scram;
  logic [KEY_W-1:0]             key_mix;
  logic [SUM_W-1:0]             sum_sel;
  logic [DIV_W-1:0]             quo_l;
  logic [COORD_W-1:0]           mean_l;
  logic                         div_start;
  logic [LANES-1:0][DIV_W-1:0]  div_dvd;
  logic [CS_W-1:0]              div_dvs;
  logic [LANES-1:0][DIV_W-1:0]  div_quo;
  logic                         div_done;
  slot_req_t                    slot_req;
  slot_entry_t                  slot_rd;
  clu_req_t                     clu_req;
  clu_entry_t                   clu_rd;
  logic [COORD_W-1:0]           coord_in [LANES];

  assign accept      = start && !busy;
  assign coord_in[0] = coord_x_i;
  assign coord_in[1] = coord_y_i;
  assign coord_in[2] = coord_z_i;
  assign key_mix     = prod_q[0] ^ prod_q[1] ^ prod_q[2];
  assign scram       = key_mix[31:0] * SCRAMBLE;

  vcw_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  vcw_slot_table u_slots (
    .clk_i   (clk_i),
    .req_i   (slot_req),
    .rdata_o (slot_rd)
  );

  vcw_cluster_store u_clusters (
    .clk_i   (clk_i),
    .req_i   (clu_req),
    .rdata_o (clu_rd)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      cs_q     <= CS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_ORIGIN_X:  org_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y:  org_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z:  org_q[2] <= cfg_data_i;
        CFG_CELL_SIZE: cs_q     <= cfg_data_i[CS_W-1:0];
        default:       cs_q     <= cs_q;
      endcase
    end
  end

  // offset from the origin per axis, sign extended
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      offs[l] = {coord_in[l][COORD_W-1], coord_in[l]} - {org_q[l][COORD_W-1], org_q[l]};
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    sweep_rep_d = sweep_rep_q;
    used_d      = used_q;
    pass_d      = pass_q;
    corner_d    = corner_q;
    first_d     = first_q;
    second_d    = second_q;
    done_d      = 1'b0;
    res_d       = res_q;
    coord_d     = coord_q;
    cell_d      = cell_q;
    prod_d      = prod_q;
    key_d       = key_q;
    hash_d      = hash_q;
    probe_d     = probe_q;
    idx_d       = idx_q;
    created_d   = created_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dvs     = (cs_q == '0) ? CS_W'(1) : cs_q;
    slot_req    = '0;
    clu_req     = '0;
    sum_sel     = '0;
    quo_l       = '0;
    mean_l      = '0;

    unique case (state_q)
      // clear every slot valid bit, one slot per cycle
      S_SWEEP: begin
        slot_req.we   = 1'b1;
        slot_req.addr = sweep_q;
        sweep_d       = sweep_q + 1'b1;
        if (sweep_q == HASH_W'(HASH_SLOTS - 1)) begin
          state_d = S_IDLE;
          if (sweep_rep_q) begin
            done_d = 1'b1;
            res_d  = '0;
          end
        end
      end

      S_IDLE: begin
        if (accept) begin
          coord_d[0] = coord_x_i;
          coord_d[1] = coord_y_i;
          coord_d[2] = coord_z_i;
          unique case (func_e'(func_i))
            FN_ADD: begin
              if (pass_q == PASS_LIMIT) begin
                done_d       = 1'b1;
                res_d        = '0;
                res_d.status = STAT_PASS_LIMIT;
              end else begin
                div_start = 1'b1;
                for (int l = 0; l < LANES; l++) begin
                  div_dvd[l] = offs[l][COORD_W] ? '0 : DIV_W'(offs[l][COORD_W-1:0]);
                end
                state_d = S_DIV;
              end
            end
            FN_READ: begin
              idx_d = query_index_i;
              if ({1'b0, query_index_i} >= used_q) begin
                done_d           = 1'b1;
                res_d            = '0;
                res_d.cluster_id = query_index_i;
                res_d.status     = STAT_BAD_INDEX;
              end else begin
                clu_req.re   = 1'b1;
                clu_req.addr = query_index_i;
                state_d      = S_RD_WAIT;
              end
            end
            FN_CLEAR: begin
              used_d      = '0;
              pass_d      = '0;
              corner_d    = '0;
              first_d     = '0;
              second_d    = '0;
              sweep_d     = '0;
              sweep_rep_d = 1'b1;
              state_d     = S_SWEEP;
            end
            default: begin
              done_d = 1'b1;
              res_d  = '0;
            end
          endcase
        end
      end

      // cell indices, saturated
      S_DIV: begin
        if (div_done) begin
          for (int l = 0; l < LANES; l++) begin
            cell_d[l] = (div_quo[l] > DIV_W'(CELL_INDEX_MAX)) ? CELL_W'(CELL_INDEX_MAX)
                                                              : div_quo[l][CELL_W-1:0];
          end
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        prod_d[0] = KEY_W'(cell_q[0]) * PRIME_X;
        prod_d[1] = KEY_W'(cell_q[1]) * PRIME_Y;
        prod_d[2] = KEY_W'(cell_q[2]) * PRIME_Z;
        state_d   = S_HASH;
      end

      S_HASH: begin
        key_d   = key_mix;
        hash_d  = scram[HASH_W-1:0];
        probe_d = '0;
        state_d = S_PROBE_RD;
      end

      S_PROBE_RD: begin
        slot_req.re   = 1'b1;
        slot_req.addr = hash_q;
        state_d       = S_PROBE_CHK;
      end

      // empty slot opens a cluster if room, match joins, else probe or fail
      S_PROBE_CHK: begin
        if (!slot_rd.valid) begin
          if (used_q >= CLU_CNT_W'(MAX_CLUSTERS)) begin
            done_d       = 1'b1;
            res_d        = '0;
            res_d.status = STAT_FULL;
            state_d      = S_IDLE;
          end else begin
            slot_req.we            = 1'b1;
            slot_req.addr          = hash_q;
            slot_req.wdata.valid   = 1'b1;
            slot_req.wdata.key     = key_q;
            slot_req.wdata.cluster = used_q[CLU_W-1:0];
            clu_req.we             = 1'b1;
            clu_req.addr           = used_q[CLU_W-1:0];
            clu_req.wdata.sum_x    = SUM_W'(signed'(coord_q[0]));
            clu_req.wdata.sum_y    = SUM_W'(signed'(coord_q[1]));
            clu_req.wdata.sum_z    = SUM_W'(signed'(coord_q[2]));
            clu_req.wdata.count    = CNT_W'(1);
            idx_d                  = used_q[CLU_W-1:0];
            used_d                 = used_q + 1'b1;
            created_d              = 1'b1;
            state_d                = S_VFIN;
          end
        end else if (slot_rd.key == key_q) begin
          idx_d        = slot_rd.cluster;
          created_d    = 1'b0;
          clu_req.re   = 1'b1;
          clu_req.addr = slot_rd.cluster;
          state_d      = S_CL_WR;
        end else if (probe_q == HASH_W'(HASH_SLOTS - 1)) begin
          done_d       = 1'b1;
          res_d        = '0;
          res_d.status = STAT_FULL;
          state_d      = S_IDLE;
        end else begin
          probe_d = probe_q + 1'b1;
          hash_d  = (hash_q == HASH_W'(HASH_SLOTS - 1)) ? '0 : hash_q + 1'b1;
          state_d = S_PROBE_RD;
        end
      end

      // accumulate into an existing cluster
      S_CL_WR: begin
        clu_req.we          = 1'b1;
        clu_req.addr        = idx_q;
        clu_req.wdata.sum_x = clu_rd.sum_x + SUM_W'(signed'(coord_q[0]));
        clu_req.wdata.sum_y = clu_rd.sum_y + SUM_W'(signed'(coord_q[1]));
        clu_req.wdata.sum_z = clu_rd.sum_z + SUM_W'(signed'(coord_q[2]));
        clu_req.wdata.count = clu_rd.count + 1'b1;
        state_d             = S_VFIN;
      end

      // triangle corners and vertex result
      S_VFIN: begin
        pass_d           = pass_q + 1'b1;
        done_d           = 1'b1;
        res_d            = '0;
        res_d.cluster_id = idx_q;
        res_d.created    = created_q;
        res_d.status     = STAT_OK;
        case (corner_q)
          2'd0: begin
            first_d  = idx_q;
            corner_d = 2'd1;
          end
          2'd1: begin
            second_d = idx_q;
            corner_d = 2'd2;
          end
          default: begin
            res_d.tri_done = 1'b1;
            res_d.tri_kept = (first_q != second_q) && (second_q != idx_q) &&
                             (first_q != idx_q);
            corner_d       = 2'd0;
          end
        endcase
        state_d = S_IDLE;
      end

      // average: magnitude division, sign restored after
      S_RD_WAIT: begin
        cnt_d = clu_rd.count;
        if (clu_rd.count == '0) begin
          done_d           = 1'b1;
          res_d            = '0;
          res_d.cluster_id = idx_q;
          state_d          = S_IDLE;
        end else begin
          div_start = 1'b1;
          div_dvs   = CS_W'(clu_rd.count);
          for (int l = 0; l < LANES; l++) begin
            sum_sel    = (l == 0) ? clu_rd.sum_x : (l == 1) ? clu_rd.sum_y : clu_rd.sum_z;
            neg_d[l]   = sum_sel[SUM_W-1];
            div_dvd[l] = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
          end
          state_d = S_RD_DIV;
        end
      end

      S_RD_DIV: begin
        if (div_done) begin
          done_d           = 1'b1;
          res_d            = '0;
          res_d.cluster_id = idx_q;
          res_d.count      = cnt_q;
          for (int l = 0; l < LANES; l++) begin
            quo_l  = div_quo[l];
            mean_l = neg_q[l] ? (~quo_l[COORD_W-1:0] + 1'b1) : quo_l[COORD_W-1:0];
            if (l == 0) res_d.mean_x = mean_l;
            else if (l == 1) res_d.mean_y = mean_l;
            else res_d.mean_z = mean_l;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      sweep_rep_q <= 1'b0;
      used_q      <= '0;
      pass_q      <= '0;
      corner_q    <= '0;
      first_q     <= '0;
      second_q    <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      sweep_rep_q <= sweep_rep_d;
      used_q      <= used_d;
      pass_q      <= pass_d;
      corner_q    <= corner_d;
      first_q     <= first_d;
      second_q    <= second_d;
      done_q      <= done_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    coord_q   <= coord_d;
    cell_q    <= cell_d;
    prod_q    <= prod_d;
    key_q     <= key_d;
    hash_q    <= hash_d;
    probe_q   <= probe_d;
    idx_q     <= idx_d;
    created_q <= created_d;
    neg_q     <= neg_d;
    cnt_q     <= cnt_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign cluster_id_o    = res_q.cluster_id;
  assign created_o       = res_q.created;
  assign triangle_done_o = res_q.tri_done;
  assign triangle_kept_o = res_q.tri_kept;
  assign mean_x_o        = res_q.mean_x;
  assign mean_y_o        = res_q.mean_y;
  assign mean_z_o        = res_q.mean_z;
  assign member_count_o  = res_q.count;
  assign status_o        = res_q.status;

`ifndef SYNTH
  // every accepted transaction either answers at once or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted transaction neither answered nor started");

  // a kept triangle is only reported on its closing vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && triangle_kept_o) |-> triangle_done_o)
    else $error("triangle kept without triangle done");

  // a rejected vertex never opens a cluster
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |-> !created_o)
    else $error("created flag on a rejected transaction");

  // cluster allocation stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CLU_CNT_W'(MAX_CLUSTERS))
    else $error("cluster count beyond store depth");
`endif

endmodule

>>> rtl/core/vcw_divider.sv
// three-lane restoring divider, one quotient bit per lane per cycle
// depends on vcw_pkg
module vcw_divider (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [vcw_pkg::LANES-1:0][vcw_pkg::DIV_W-1:0] dividend_i,
  input  logic [vcw_pkg::CS_W-1:0]              divisor_i,
  output logic [vcw_pkg::LANES-1:0][vcw_pkg::DIV_W-1:0] quotient_o,
  output logic                                  done_o
);
  import vcw_pkg::*;

  logic [LANES-1:0][DIV_W-1:0] quo_q, quo_d;
  logic [LANES-1:0][CS_W-1:0]  rem_q, rem_d;
  logic [CS_W-1:0]             dvs_q, dvs_d;
  logic [DCNT_W-1:0]           cnt_q, cnt_d;
  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [CS_W:0]               rem_sh;

  // load on start, else one shift-subtract step on every lane while running
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_sh = '0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      for (int l = 0; l < LANES; l++) begin
        rem_sh = {rem_q[l], quo_q[l][DIV_W-1]};
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d[l] = CS_W'(rem_sh - {1'b0, dvs_q});
          quo_d[l] = {quo_q[l][DIV_W-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_sh[CS_W-1:0];
          quo_d[l] = {quo_q[l][DIV_W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DIV_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> rtl/core/vcw_slot_table.sv
// open-addressed hash slot memory, one port, registered read
// depends on vcw_pkg
module vcw_slot_table (
  input  logic                 clk_i,
  input  vcw_pkg::slot_req_t   req_i,
  output vcw_pkg::slot_entry_t rdata_o
);
  import vcw_pkg::*;

  slot_entry_t mem [HASH_SLOTS];
  slot_entry_t rdata_q;

  // single port access
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/vcw_cluster_store.sv
// per-cluster sums and member count memory, registered read
// depends on vcw_pkg
module vcw_cluster_store (
  input  logic                clk_i,
  input  vcw_pkg::clu_req_t   req_i,
  output vcw_pkg::clu_entry_t rdata_o
);
  import vcw_pkg::*;

  clu_entry_t mem [MAX_CLUSTERS];
  clu_entry_t rdata_q;

  // single port access
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
